FILE: rtl/core/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg
// Shared types and constants for the Euler point rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epr_pkg;

    localparam int COORD_W   = 32;
    localparam int ANGLE_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Q1.30 matrix term
    typedef logic signed [31:0] coef_t;

    // row-major 3x3 rotation matrix
    typedef struct packed {
        coef_t [8:0] m;
    } mat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YAW   = 2'd0,
        CFG_PITCH = 2'd1,
        CFG_ROLL  = 2'd2
    } cfg_idx_t;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // clamp a rounded row sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/euler_point_rotator_core.sv
// ----------------------------------------------------------------------------
// euler_point_rotator_core
// Z-Y-X (yaw, pitch, roll) rotation of Q16.16 points by a configured matrix.
//
// Usage:
//  - Config: cfg_we writes cfg_data[15:0] to yaw (0), pitch (1) or roll (2);
//    angles are binary, 32768 = pi. Other indexes are ignored. Write only
//    with the point stream drained.
//  - Any write (and reset) starts a matrix rebuild: three angles (setup,
//    eleven series steps of multiply, reciprocal divide and update, and
//    quadrant fixup), then fifteen multiply steps. s_ready is low during
//    it.
//  - Points: s_valid/s_ready carry one item (x, y, z) in; m_valid/m_ready
//    carry the rotated item out. Outputs are rounded and saturated.
//  - Throughput one item per cycle unless m_ready stalls or a matrix
//    rebuild runs; three register stages (products, row sums, saturation).
//  - A stall at m_ready holds the last stage; earlier stages keep filling
//    bubbles, so up to two more items are taken while a result waits.
//  - Reset: angles return to zero (identity), pipeline empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module euler_point_rotator_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [epr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [epr_pkg::ANGLE_W-1:0]          cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [epr_pkg::COORD_W-1:0]   s_in_x,
    input  wire logic signed [epr_pkg::COORD_W-1:0]   s_in_y,
    input  wire logic signed [epr_pkg::COORD_W-1:0]   s_in_z,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [epr_pkg::COORD_W-1:0]        m_out_x,
    output logic signed [epr_pkg::COORD_W-1:0]        m_out_y,
    output logic signed [epr_pkg::COORD_W-1:0]        m_out_z
);
    import epr_pkg::*;

    logic [ANGLE_W-1:0] yaw_reg, pitch_reg, roll_reg;
    logic mat_busy;
    logic pipe_ready;
    mat_t mat;

    // angle registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
            roll_reg  <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_YAW)   yaw_reg   <= cfg_data;
            if (cfg_index == CFG_PITCH) pitch_reg <= cfg_data;
            if (cfg_index == CFG_ROLL)  roll_reg  <= cfg_data;
        end
    end

    // matrix is rebuilt after every write; the pipeline reads it as static
    epr_mat u_mat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_we),
        .yaw     (yaw_reg),
        .pitch   (pitch_reg),
        .roll    (roll_reg),
        .busy    (mat_busy),
        .mat     (mat)
    );

    assign s_ready = pipe_ready && !mat_busy;

    epr_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mat       (mat),
        .in_valid  (s_valid && !mat_busy),
        .in_ready  (pipe_ready),
        .in_x      (s_in_x),
        .in_y      (s_in_y),
        .in_z      (s_in_z),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_x     (m_out_x),
        .out_y     (m_out_y),
        .out_z     (m_out_z)
    );

endmodule

`default_nettype wire

FILE: rtl/core/epr_div.sv
// ----------------------------------------------------------------------------
// epr_div
// Constant divider for the series divisors, by reciprocal multiplication.
// The product is registered at start; done and quotient follow in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epr_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [7:0]  divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    logic        done_reg;
    logic [5:0]  sh_reg;
    logic [63:0] prod_reg;
    logic [31:0] recip;
    logic [5:0]  sh;

    // recip = ceil(2^sh / k), sh = 31 + ceil(log2 k); exact for dividends below 2^31
    always_comb begin
        unique case (divisor)
            8'd110: begin recip = 32'(((64'd1 << 38) + 64'd109) / 64'd110); sh = 6'd38; end
            8'd72:  begin recip = 32'(((64'd1 << 38) + 64'd71) / 64'd72);   sh = 6'd38; end
            8'd42:  begin recip = 32'(((64'd1 << 37) + 64'd41) / 64'd42);   sh = 6'd37; end
            8'd20:  begin recip = 32'(((64'd1 << 36) + 64'd19) / 64'd20);   sh = 6'd36; end
            8'd6:   begin recip = 32'(((64'd1 << 34) + 64'd5) / 64'd6);     sh = 6'd34; end
            8'd132: begin recip = 32'(((64'd1 << 39) + 64'd131) / 64'd132); sh = 6'd39; end
            8'd90:  begin recip = 32'(((64'd1 << 38) + 64'd89) / 64'd90);   sh = 6'd38; end
            8'd56:  begin recip = 32'(((64'd1 << 37) + 64'd55) / 64'd56);   sh = 6'd37; end
            8'd30:  begin recip = 32'(((64'd1 << 36) + 64'd29) / 64'd30);   sh = 6'd36; end
            8'd12:  begin recip = 32'(((64'd1 << 35) + 64'd11) / 64'd12);   sh = 6'd35; end
            default: begin recip = 32'h8000_0000; sh = 6'd32; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= 64'(dividend) * 64'(recip);
            sh_reg   <= sh;
        end
    end

    assign done     = done_reg;
    assign quotient = 32'(prod_reg >> sh_reg);

endmodule

`default_nettype wire

FILE: rtl/core/epr_mat.sv
// ----------------------------------------------------------------------------
// epr_mat
// Matrix builder: series sine/cosine per angle, then the nine Q1.30 terms,
// all on one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epr_mat (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        restart,
    input  wire logic [epr_pkg::ANGLE_W-1:0] yaw,
    input  wire logic [epr_pkg::ANGLE_W-1:0] pitch,
    input  wire logic [epr_pkg::ANGLE_W-1:0] roll,
    output logic                             busy,
    output epr_pkg::mat_t                    mat
);
    import epr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ANG, ST_SQ, ST_SQW, ST_HMUL, ST_HDIV, ST_HWAIT,
        ST_SV, ST_QUAD, ST_MMUL, ST_MACT
    } state_t;

    typedef enum logic [2:0] {
        OP_SY, OP_CY, OP_SP, OP_CP, OP_SR, OP_CR, OP_SPSR, OP_SPCR
    } opnd_t;

    typedef enum logic [2:0] {
        ACT_SPSR, ACT_SPCR, ACT_TMP, ACT_SET, ACT_ADD, ACT_SUB, ACT_NEG
    } act_t;

    typedef struct packed {
        opnd_t      a;
        opnd_t      b;
        act_t       act;
        logic [3:0] dst;
    } mstep_t;

    localparam logic [33:0] PI_Q32    = 34'd13493037705;
    localparam logic [3:0]  SIN_STEPS = 4'd5;
    localparam logic [3:0]  LAST_H    = 4'd10;
    localparam logic [3:0]  LAST_M    = 4'd14;
    localparam logic [1:0]  LAST_ANG  = 2'd2;

    // Horner divisors: sine terms, cosine terms, then the final half
    function automatic logic [7:0] hdiv(input logic [3:0] j);
        unique case (j)
            4'd0:    return 8'd110;
            4'd1:    return 8'd72;
            4'd2:    return 8'd42;
            4'd3:    return 8'd20;
            4'd4:    return 8'd6;
            4'd5:    return 8'd132;
            4'd6:    return 8'd90;
            4'd7:    return 8'd56;
            4'd8:    return 8'd30;
            4'd9:    return 8'd12;
            default: return 8'd2;
        endcase
    endfunction

    function automatic mstep_t mstep(input logic [3:0] s);
        unique case (s)
            4'd0:    return '{OP_CY,   OP_SP, ACT_SPSR, 4'd0};
            4'd1:    return '{OP_SY,   OP_SP, ACT_SPCR, 4'd0};
            4'd2:    return '{OP_CY,   OP_CP, ACT_SET,  4'd0};
            4'd3:    return '{OP_SPSR, OP_SR, ACT_TMP,  4'd0};
            4'd4:    return '{OP_SY,   OP_CR, ACT_SUB,  4'd1};
            4'd5:    return '{OP_SPSR, OP_CR, ACT_TMP,  4'd0};
            4'd6:    return '{OP_SY,   OP_SR, ACT_ADD,  4'd2};
            4'd7:    return '{OP_SY,   OP_CP, ACT_SET,  4'd3};
            4'd8:    return '{OP_SPCR, OP_SR, ACT_TMP,  4'd0};
            4'd9:    return '{OP_CY,   OP_CR, ACT_ADD,  4'd4};
            4'd10:   return '{OP_SPCR, OP_CR, ACT_TMP,  4'd0};
            4'd11:   return '{OP_CY,   OP_SR, ACT_SUB,  4'd5};
            4'd12:   return '{OP_SP,   OP_SP, ACT_NEG,  4'd6};
            4'd13:   return '{OP_CP,   OP_SR, ACT_SET,  4'd7};
            default: return '{OP_CP,   OP_CR, ACT_SET,  4'd8};
        endcase
    endfunction

    // signed Q1.30 product, round half up
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return 32'(p >>> 30);
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        if (v > 34'sd1073741824) begin
            return ONE_Q30;
        end else if (v < -34'sd1073741824) begin
            return -ONE_Q30;
        end
        return 32'(v);
    endfunction

    state_t state_reg;
    logic          busy_reg;
    logic [1:0]    ang_reg;
    logic [3:0]    j_reg;
    logic [3:0]    step_reg;
    logic [1:0]    quad_reg;
    logic          swap_reg;
    logic [30:0]   x_reg, x2_reg, hs_reg, hc_reg;
    logic signed [31:0] prod_reg, tmp_reg;
    logic signed [31:0] sy_reg, cy_reg, sp_reg, cp_reg, sr_reg, cr_reg;
    logic signed [31:0] spsr_reg, spcr_reg;
    mat_t          mat_reg;

    logic [15:0]   ang_val;
    logic [13:0]   r_frac;
    logic          swap;
    logic [13:0]   t_red;
    logic [48:0]   x_full;
    logic signed [31:0] mul_a, mul_b, opa, opb;
    logic signed [31:0] sv, cv, s0, c0, s_out, c_out;
    logic [7:0]    hk;
    logic          div_start, div_done;
    logic [31:0]   div_n, div_q;
    logic [30:0]   h_new;
    mstep_t        cur;

    // angle reduction to the first octant
    always_comb begin
        unique case (ang_reg)
            2'd0:    ang_val = yaw;
            2'd1:    ang_val = pitch;
            default: ang_val = roll;
        endcase
        r_frac = ang_val[13:0];
        swap   = r_frac > 14'd8192;
        t_red  = swap ? 14'(15'd16384 - {1'b0, r_frac}) : r_frac;
        x_full = 49'(t_red) * 49'(PI_Q32) + 49'd65536;
    end

    function automatic logic signed [31:0] pick(input opnd_t c,
        input logic signed [31:0] a0, input logic signed [31:0] a1,
        input logic signed [31:0] a2, input logic signed [31:0] a3,
        input logic signed [31:0] a4, input logic signed [31:0] a5,
        input logic signed [31:0] a6, input logic signed [31:0] a7);
        unique case (c)
            OP_SY:   return a0;
            OP_CY:   return a1;
            OP_SP:   return a2;
            OP_CP:   return a3;
            OP_SR:   return a4;
            OP_CR:   return a5;
            OP_SPSR: return a6;
            default: return a7;
        endcase
    endfunction

    always_comb begin
        cur = mstep(step_reg);
        opa = pick(cur.a, sy_reg, cy_reg, sp_reg, cp_reg, sr_reg, cr_reg,
                   spsr_reg, spcr_reg);
        opb = pick(cur.b, sy_reg, cy_reg, sp_reg, cp_reg, sr_reg, cr_reg,
                   spsr_reg, spcr_reg);
        unique case (state_reg)
            ST_SQ: begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            ST_HMUL: begin
                mul_a = {1'b0, x2_reg};
                mul_b = (j_reg < SIN_STEPS) ? {1'b0, hs_reg} : {1'b0, hc_reg};
            end
            ST_SV: begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, hs_reg};
            end
            ST_MMUL, ST_MACT: begin
                mul_a = opa;
                mul_b = opb;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // quadrant: swap and sign the octant pair
    always_comb begin
        sv = prod_reg;
        cv = {1'b0, hc_reg};
        s0 = swap_reg ? cv : sv;
        c0 = swap_reg ? sv : cv;
        unique case (quad_reg)
            2'd0: begin s_out = s0;  c_out = c0;  end
            2'd1: begin s_out = c0;  c_out = -s0; end
            2'd2: begin s_out = -s0; c_out = -c0; end
            default: begin s_out = -c0; c_out = s0; end
        endcase
    end

    assign hk        = hdiv(j_reg);
    assign div_start = (state_reg == ST_HDIV);
    assign div_n     = $unsigned(prod_reg) + {25'd0, hk[7:1]};
    assign h_new     = 31'($unsigned(ONE_Q30) - div_q);

    epr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (hk),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mulq(mul_a, mul_b);
        if (!aresetn) begin
            state_reg <= ST_ANG;
            busy_reg  <= 1'b1;
            ang_reg   <= '0;
            j_reg     <= '0;
            step_reg  <= '0;
        end else if (restart) begin
            state_reg <= ST_ANG;
            busy_reg  <= 1'b1;
            ang_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    busy_reg <= 1'b0;
                end
                ST_ANG: begin
                    x_reg     <= 31'(x_full >> 17);
                    quad_reg  <= ang_val[15:14];
                    swap_reg  <= swap;
                    hs_reg    <= 31'(ONE_Q30);
                    hc_reg    <= 31'(ONE_Q30);
                    j_reg     <= '0;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    state_reg <= ST_SQW;
                end
                ST_SQW: begin
                    x2_reg    <= 31'(prod_reg);
                    state_reg <= ST_HMUL;
                end
                ST_HMUL: begin
                    state_reg <= ST_HDIV;
                end
                ST_HDIV: begin
                    state_reg <= ST_HWAIT;
                end
                ST_HWAIT: begin
                    if (div_done) begin
                        if (j_reg < SIN_STEPS) begin
                            hs_reg <= h_new;
                        end else begin
                            hc_reg <= h_new;
                        end
                        if (j_reg == LAST_H) begin
                            state_reg <= ST_SV;
                        end else begin
                            j_reg     <= j_reg + 4'd1;
                            state_reg <= ST_HMUL;
                        end
                    end
                end
                ST_SV: begin
                    state_reg <= ST_QUAD;
                end
                ST_QUAD: begin
                    unique case (ang_reg)
                        2'd0: begin sy_reg <= s_out; cy_reg <= c_out; end
                        2'd1: begin sp_reg <= s_out; cp_reg <= c_out; end
                        default: begin sr_reg <= s_out; cr_reg <= c_out; end
                    endcase
                    if (ang_reg == LAST_ANG) begin
                        step_reg  <= '0;
                        state_reg <= ST_MMUL;
                    end else begin
                        ang_reg   <= ang_reg + 2'd1;
                        state_reg <= ST_ANG;
                    end
                end
                ST_MMUL: begin
                    state_reg <= ST_MACT;
                end
                ST_MACT: begin
                    unique case (cur.act)
                        ACT_SPSR: spsr_reg <= prod_reg;
                        ACT_SPCR: spcr_reg <= prod_reg;
                        ACT_TMP:  tmp_reg  <= prod_reg;
                        ACT_SET:  mat_reg.m[cur.dst] <= clamp_unit(34'(prod_reg));
                        ACT_ADD:  mat_reg.m[cur.dst] <=
                                      clamp_unit(34'(tmp_reg) + 34'(prod_reg));
                        ACT_SUB:  mat_reg.m[cur.dst] <=
                                      clamp_unit(34'(tmp_reg) - 34'(prod_reg));
                        default:  mat_reg.m[cur.dst] <= clamp_unit(-34'(opa));
                    endcase
                    if (step_reg == LAST_M) begin
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end else begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= ST_MMUL;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign mat  = mat_reg;

endmodule

`default_nettype wire

FILE: rtl/core/epr_pipe.sv
// ----------------------------------------------------------------------------
// epr_pipe
// Three-stage point transform: products, rounded row sums, saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epr_pipe (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire epr_pkg::mat_t                      mat,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [epr_pkg::COORD_W-1:0] in_x,
    input  wire logic signed [epr_pkg::COORD_W-1:0] in_y,
    input  wire logic signed [epr_pkg::COORD_W-1:0] in_z,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [epr_pkg::COORD_W-1:0]      out_x,
    output logic signed [epr_pkg::COORD_W-1:0]      out_y,
    output logic signed [epr_pkg::COORD_W-1:0]      out_z
);
    import epr_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic signed [COORD_W-1:0] pt [3];
    logic signed [63:0] prod_reg [9];
    logic signed [65:0] acc [3];
    logic signed [35:0] rnd [3];
    logic signed [35:0] rsum_reg [3];
    logic signed [COORD_W-1:0] res_reg [3];

    assign pt[0] = in_x;
    assign pt[1] = in_y;
    assign pt[2] = in_z;

    // each stage loads when empty or when the next one moves
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = 66'(prod_reg[3*r]) + 66'(prod_reg[3*r+1])
                   + 66'(prod_reg[3*r+2]) + 66'sd536870912;
            rnd[r] = 36'(acc[r] >>> 30);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && rdy1) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[3*r+c] <= 64'(mat.m[3*r+c]) * 64'(pt[c]);
                end
            end
        end
        if (v1_reg && rdy2) begin
            for (int r = 0; r < 3; r++) rsum_reg[r] <= rnd[r];
        end
        if (v2_reg && rdy3) begin
            for (int r = 0; r < 3; r++) res_reg[r] <= sat32(rsum_reg[r]);
        end
    end

    assign out_valid = v3_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];

endmodule

`default_nettype wire

FILE: rtl/core/epr_chk.sv
// ----------------------------------------------------------------------------
// epr_chk
// Port-level checks for the rotator core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epr_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_out_x,
    input wire logic [31:0] m_out_y,
    input wire logic [31:0] m_out_z
);

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid after reset");

    // reset starts a matrix rebuild, so no item is taken
    a_rst_busy: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("s_ready right after reset");

    // a config write blocks input until the matrix is rebuilt
    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("s_ready right after config write");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x)
                                && $stable(m_out_y) && $stable(m_out_z))
        else $error("stalled result changed");

endmodule

bind euler_point_rotator_core epr_chk u_epr_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .cfg_we  (cfg_we),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_out_x (m_out_x),
    .m_out_y (m_out_y),
    .m_out_z (m_out_z)
);

`default_nettype wire
